### hw/rtl/dpm_pkg.sv
// Shared types and constants of the decimating power meter.
package dpm_pkg;

    localparam int NORM_W     = 64;
    localparam int MANT_W     = 32;
    localparam int FRAC_BITS  = 20;
    localparam int LOG_INT_W  = 6;
    localparam int LOG_W      = LOG_INT_W + FRAC_BITS;
    localparam int NORM_STEPS = 6;
    localparam int STEP_W     = 5;
    localparam int DIFF_W     = 28;
    localparam int K_W        = 24;
    localparam int PROD_W     = DIFF_W + K_W;
    localparam int RND_SHIFT  = 2 * FRAC_BITS - 8;
    localparam int Q_W        = PROD_W - RND_SHIFT;
    localparam int DB_W       = 16;
    localparam int JOBQ_DEPTH = 2;

    // 10*log10(2) in Q.20
    localparam logic signed [K_W-1:0] TEN_LOG10_2_Q20 = K_W'(3156528);
    localparam logic signed [DB_W-1:0] DB_MIN = 16'sh8000;
    localparam logic signed [DB_W-1:0] DB_MAX = 16'sh7FFF;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE
    } t_log_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SUM_GO,
        BK_SUM_WAIT,
        BK_CNT_GO,
        BK_CNT_WAIT,
        BK_MUL,
        BK_OUT
    } t_back_state;

    // accumulator width: full range of a block, capped at the 64-bit saturation point
    function automatic int sum_width(input int sw, input int cw);
        int w;
        w = 2 * sw - 1 + cw;
        return (w > NORM_W) ? NORM_W : w;
    endfunction

endpackage

### hw/rtl/dpm_front.sv
// Front end: squares samples, accumulates power and closes blocks into jobs.
module dpm_front
    import dpm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [COUNT_WIDTH-1:0]         i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                           o_job_push,
    output logic [sum_width(SAMPLE_WIDTH, COUNT_WIDTH)-1:0] o_job_sum,
    output logic [COUNT_WIDTH-1:0]         o_job_cnt,
    input  logic                           i_job_full
);

    localparam int E_W   = 2 * SAMPLE_WIDTH;
    localparam int SUM_W = sum_width(SAMPLE_WIDTH, COUNT_WIDTH);

    logic signed [E_W-1:0]   sq_i;
    logic signed [E_W-1:0]   sq_q;
    logic [E_W-1:0]          n_e;
    logic [E_W-1:0]          r_e;
    logic                    r_e_valid;
    logic [SUM_W-1:0]        r_sum;
    logic [COUNT_WIDTH-1:0]  r_seen;
    logic [COUNT_WIDTH-1:0]  r_spr;
    logic [SUM_W:0]          sum_ext;
    logic [SUM_W-1:0]        sum_sat;
    logic [COUNT_WIDTH:0]    n_cnt;
    logic                    close;
    logic                    adv;
    logic                    take;

    assign sq_i = E_W'(i_sample_i) * E_W'(i_sample_i);
    assign sq_q = E_W'(i_sample_q) * E_W'(i_sample_q);
    assign n_e  = $unsigned(sq_i) + $unsigned(sq_q);

    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_e);
    assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    assign n_cnt   = {1'b0, r_seen} + (COUNT_WIDTH + 1)'(1);
    assign close   = n_cnt >= {1'b0, r_spr};

    assign adv    = r_e_valid && (!close || !i_job_full);
    assign o_full = r_e_valid && !adv;
    assign take   = i_push && !o_full;

    assign o_job_push = adv && close;
    assign o_job_sum  = sum_sat;
    assign o_job_cnt  = n_cnt[COUNT_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_sum     <= '0;
            r_seen    <= '0;
            r_spr     <= COUNT_WIDTH'(1024);
        end else begin
            if (i_cfg_we) begin
                r_spr <= i_cfg_data;
            end
            if (take) begin
                r_e_valid <= 1'b1;
            end else if (adv) begin
                r_e_valid <= 1'b0;
            end
            if (adv) begin
                if (close) begin
                    r_sum  <= '0;
                    r_seen <= '0;
                end else begin
                    r_sum  <= sum_sat;
                    r_seen <= n_cnt[COUNT_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_e <= n_e;
        end
    end

endmodule

### hw/rtl/dpm_jobq.sv
// Short queue of closed blocks between the front end and the back end.
module dpm_jobq
    import dpm_pkg::*;
#(
    parameter int WIDTH = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = r_cnt == CNT_W'(JOBQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### hw/rtl/dpm_log2.sv
// Iterative log2 unit: normalize by halving shifts, then fraction bits by squaring.
module dpm_log2
    import dpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NORM_W-1:0] i_x,
    output logic              o_done,
    output logic [LOG_W-1:0]  o_log
);

    localparam int AMT_W = $clog2(NORM_W) + 1;

    t_log_state              r_state;
    t_log_state              n_state;
    logic [NORM_W-1:0]       r_x;
    logic [LOG_INT_W-1:0]    r_p;
    logic [FRAC_BITS-1:0]    r_frac;
    logic [STEP_W-1:0]       r_step;
    logic                    r_done;
    logic [AMT_W-1:0]        amt;
    logic                    hi_zero;
    logic [2*MANT_W-1:0]     sq;
    logic [MANT_W:0]         sq_t;
    logic [MANT_W-1:0]       n_m;
    logic                    load;
    logic                    norm_en;
    logic                    sq_en;
    logic                    norm_last;
    logic                    sq_last;

    assign amt     = AMT_W'(NORM_W / 2) >> r_step[2:0];
    assign hi_zero = (r_x >> (AMT_W'(NORM_W) - amt)) == '0;
    assign sq      = r_x[NORM_W-1 -: MANT_W] * r_x[NORM_W-1 -: MANT_W];
    assign sq_t    = sq[2*MANT_W-1:MANT_W-1];
    assign n_m     = sq_t[MANT_W] ? sq_t[MANT_W:1] : sq_t[MANT_W-1:0];

    assign norm_last = r_step == STEP_W'(NORM_STEPS - 1);
    assign sq_last   = r_step == STEP_W'(FRAC_BITS - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            LG_IDLE:   if (i_start) n_state = LG_NORM;
            LG_NORM:   if (norm_last) n_state = LG_SQUARE;
            LG_SQUARE: if (sq_last) n_state = LG_IDLE;
            default:   n_state = LG_IDLE;
        endcase
    end

    always_comb begin
        load    = (r_state == LG_IDLE) && i_start;
        norm_en = r_state == LG_NORM;
        sq_en   = r_state == LG_SQUARE;
    end

    assign o_done = r_done;
    assign o_log  = {r_p, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= sq_en && sq_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x    <= i_x;
            r_p    <= LOG_INT_W'(NORM_W - 1);
            r_frac <= '0;
            r_step <= '0;
        end else if (norm_en) begin
            if (hi_zero) begin
                r_x <= r_x << amt;
                r_p <= r_p - amt[LOG_INT_W-1:0];
            end
            r_step <= norm_last ? '0 : r_step + STEP_W'(1);
        end else if (sq_en) begin
            r_x    <= {n_m, {(NORM_W - MANT_W){1'b0}}};
            r_frac <= {r_frac[FRAC_BITS-2:0], sq_t[MANT_W]};
            r_step <= r_step + STEP_W'(1);
        end
    end

endmodule

### hw/rtl/dpm_back.sv
// Back end: log2 of nonzero sum and count, scale to dB, round, clamp, hold result.
module dpm_back
    import dpm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_job_empty,
    input  logic [sum_width(SAMPLE_WIDTH, COUNT_WIDTH)-1:0] i_job_sum,
    input  logic [COUNT_WIDTH-1:0] i_job_cnt,
    output logic                   o_job_pop,
    output logic                   o_log_start,
    output logic [NORM_W-1:0]      o_log_x,
    input  logic                   i_log_done,
    input  logic [LOG_W-1:0]       i_log_val,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic signed [DB_W-1:0] o_power_db
);

    localparam int SUM_W = sum_width(SAMPLE_WIDTH, COUNT_WIDTH);
    localparam logic signed [DIFF_W-1:0] FS_OFFSET =
        DIFF_W'((2 * (SAMPLE_WIDTH - 1)) * (2 ** FRAC_BITS));

    t_back_state               r_state;
    t_back_state               n_state;
    logic [SUM_W-1:0]          r_sum;
    logic [COUNT_WIDTH-1:0]    r_cnt;
    logic                      r_zero;
    logic [LOG_W-1:0]          r_lsum;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [DIFF_W-1:0]  n_diff;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DB_W-1:0]    r_out;
    logic                      r_out_valid;
    logic                      out_free;
    logic                      out_load;
    logic                      neg;
    logic [PROD_W-1:0]         mag;
    logic [PROD_W-1:0]         rsum;
    logic [Q_W-1:0]            q;
    logic signed [DB_W-1:0]    db;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_job_empty) n_state = (i_job_sum == '0) ? BK_OUT : BK_SUM_GO;
            end
            BK_SUM_GO:   n_state = BK_SUM_WAIT;
            BK_SUM_WAIT: if (i_log_done) n_state = BK_CNT_GO;
            BK_CNT_GO:   n_state = BK_CNT_WAIT;
            BK_CNT_WAIT: if (i_log_done) n_state = BK_MUL;
            BK_MUL:      n_state = BK_OUT;
            BK_OUT:      if (out_free) n_state = BK_IDLE;
            default:     n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop   = (r_state == BK_IDLE) && !i_job_empty;
        o_log_start = (r_state == BK_SUM_GO) || (r_state == BK_CNT_GO);
        o_log_x     = (r_state == BK_CNT_GO) ? NORM_W'(r_cnt) : NORM_W'(r_sum);
        out_load    = (r_state == BK_OUT) && out_free;
    end

    assign n_diff = $signed({{(DIFF_W - LOG_W){1'b0}}, r_lsum})
                  - $signed({{(DIFF_W - LOG_W){1'b0}}, i_log_val}) - FS_OFFSET;

    // round half away from zero to Q8.8, then clamp
    assign neg  = r_prod[PROD_W-1];
    assign mag  = neg ? $unsigned(-r_prod) : $unsigned(r_prod);
    assign rsum = mag + (PROD_W'(1) << (RND_SHIFT - 1));
    assign q    = rsum[PROD_W-1:RND_SHIFT];

    always_comb begin
        if (r_zero) begin
            db = DB_MIN;
        end else if (neg) begin
            db = (q > Q_W'(32768)) ? DB_MIN : $signed(DB_W'(-q));
        end else begin
            db = (q > Q_W'(32767)) ? DB_MAX : $signed(q[DB_W-1:0]);
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_power_db = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_sum  <= i_job_sum;
            r_cnt  <= i_job_cnt;
            r_zero <= i_job_sum == '0;
        end
        if ((r_state == BK_SUM_WAIT) && i_log_done) begin
            r_lsum <= i_log_val;
        end
        if ((r_state == BK_CNT_WAIT) && i_log_done) begin
            r_diff <= n_diff;
        end
        if (r_state == BK_MUL) begin
            r_prod <= PROD_W'(r_diff) * PROD_W'(TEN_LOG10_2_Q20);
        end
        if (out_load) begin
            r_out <= db;
        end
    end

endmodule

### hw/rtl/decimating_power_meter_db.sv
// Top level of the decimating power meter: block mean power of I/Q samples in dBFS.
//
// Input queue side: present i_sample_i/i_sample_q with push; a transfer happens
// on a clock edge with push high and full low. Samples are taken one per cycle while full stays low.
// Each sample adds I*I+Q*Q to the open block; the sample that brings the count
// to i_cfg_data's stored value (0 acts as 1) closes the block.
// Result queue side: o_power_db is valid while empty is low (signed Q8.8 dBFS,
// minimum code for a zero-power block); a transfer happens when pop is high.
// A closed block's result passes through the job queue, the shared log2 unit (6
// normalize steps plus 20 squaring steps, once for the sum and once for the
// count) and one scaling multiply before empty falls; a zero-power block
// skips the log2 unit and the multiply.
// Throughput: one sample per cycle while blocks are long; the back end works
// on one block at a time, so with short blocks the two-entry job queue
// fills and full throttles input to the back end's pace.
// A stalled receiver holds the result register; the back end then waits, the
// job queue fills, and finally full rises.
// Reset clears the accumulator, sample count, queues and result valid flag and
// loads a block length of 1024. Write i_cfg_we/i_cfg_data only while idle.
module decimating_power_meter_db
    import dpm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [COUNT_WIDTH-1:0]         i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_q,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [DB_W-1:0]         o_power_db
);

    localparam int SUM_W = sum_width(SAMPLE_WIDTH, COUNT_WIDTH);
    localparam int JOB_W = SUM_W + COUNT_WIDTH;

    logic                   job_push;
    logic [SUM_W-1:0]       job_sum_in;
    logic [COUNT_WIDTH-1:0] job_cnt_in;
    logic                   job_full;
    logic                   job_pop;
    logic                   job_empty;
    logic [JOB_W-1:0]       job_data;
    logic                   log_start;
    logic [NORM_W-1:0]      log_x;
    logic                   log_done;
    logic [LOG_W-1:0]       log_val;

    dpm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .o_full     (full),
        .i_sample_i (i_sample_i),
        .i_sample_q (i_sample_q),
        .o_job_push (job_push),
        .o_job_sum  (job_sum_in),
        .o_job_cnt  (job_cnt_in),
        .i_job_full (job_full)
    );

    dpm_jobq #(
        .WIDTH (JOB_W)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({job_sum_in, job_cnt_in}),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_data),
        .o_empty (job_empty)
    );

    dpm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_x     (log_x),
        .o_done  (log_done),
        .o_log   (log_val)
    );

    dpm_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job_sum   (job_data[JOB_W-1:COUNT_WIDTH]),
        .i_job_cnt   (job_data[COUNT_WIDTH-1:0]),
        .o_job_pop   (job_pop),
        .o_log_start (log_start),
        .o_log_x     (log_x),
        .i_log_done  (log_done),
        .i_log_val   (log_val),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_power_db  (o_power_db)
    );

    // a closed block is never dropped at the job queue
    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !job_full)
        else $error("job pushed into a full queue");

    a_job_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty)
        else $error("job popped from an empty queue");

    // the log unit start is never asserted back to back
    a_log_start_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        log_start |=> !log_start)
        else $error("log unit restarted back to back");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending right after reset");

endmodule

### verif/decimating_power_meter_db_test.sv
// Self-checking testbench for the decimating power meter: block mean power of I/Q samples.
module decimating_power_meter_db_test
    import dpm_pkg::*;
();

    localparam int SAMPLE_W      = 16;
    localparam int COUNT_W       = 16;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_PRINTS    = 40;
    localparam int N_DIRECTED    = 17;
    localparam int N_PHASES      = 12;
    localparam logic [COUNT_W-1:0] RESET_BLOCK_LEN = 16'd1024;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic                       known;
        logic signed [DB_W-1:0]     db;
    } t_directed_row;

    typedef struct packed {
        logic [COUNT_W-1:0] block_len;
        logic [7:0]         idle_pct;
        logic [7:0]         stall_pct;
        logic [15:0]        n_samples;
    } t_phase;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [COUNT_W-1:0]         i_cfg_data;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] i_sample_i;
    logic signed [SAMPLE_W-1:0] i_sample_q;
    logic                       empty;
    logic                       pop;
    logic signed [DB_W-1:0]     o_power_db;

    // predictor state
    logic [COUNT_W-1:0]     block_len;
    longint unsigned        power_acc;
    longint unsigned        samples_in_block;
    logic signed [DB_W-1:0] pending_db[$];

    int idle_pct;
    int stall_pct;
    int error_count;
    int samples_sent;
    int results_checked;
    int lengths_used;
    int cycle_count;

    t_directed_row directed_rows [N_DIRECTED];
    t_phase        phase_plan [N_PHASES];

    decimating_power_meter_db #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .COUNT_WIDTH (COUNT_W)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .push      (push),
        .full      (full),
        .i_sample_i(i_sample_i),
        .i_sample_q(i_sample_q),
        .empty     (empty),
        .pop       (pop),
        .o_power_db(o_power_db)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR @%0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    // log2 in Q.20, truncated, by repeated squaring of a Q1.31 mantissa
    function automatic longint log2_q20(input longint unsigned x);
        int              p;
        longint unsigned m;
        longint          frac;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        if (p >= 31) begin
            m = x >> (p - 31);
        end else begin
            m = x << (31 - p);
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(p) <<< FRAC_BITS) + frac;
    endfunction

    function automatic logic signed [DB_W-1:0] block_power_db(input longint unsigned sum,
                                                              input longint unsigned cnt);
        longint diff;
        longint prod;
        longint mag;
        longint q;
        if (sum == 0) return DB_MIN;
        if (cnt == 0) cnt = 1;
        diff = log2_q20(sum) - log2_q20(cnt) - (longint'(2 * (SAMPLE_W - 1)) <<< FRAC_BITS);
        prod = diff * longint'(TEN_LOG10_2_Q20);
        mag = (prod < 0) ? -prod : prod;
        q = (mag + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        if (prod < 0) q = -q;
        if (q < longint'(DB_MIN)) q = longint'(DB_MIN);
        if (q > longint'(DB_MAX)) q = longint'(DB_MAX);
        return DB_W'(q);
    endfunction

    // returns 1 when the sample closes a block
    function automatic logic absorb_sample(input logic signed [SAMPLE_W-1:0] si,
                                           input logic signed [SAMPLE_W-1:0] sq,
                                           output logic signed [DB_W-1:0] db);
        longint unsigned e;
        longint unsigned n;
        e = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
        if (power_acc > ~64'd0 - e) begin
            power_acc = ~64'd0;
        end else begin
            power_acc = power_acc + e;
        end
        n = samples_in_block + 1;
        db = '0;
        if (n >= longint'(block_len)) begin
            db = block_power_db(power_acc, n);
            power_acc = 0;
            samples_in_block = 0;
            return 1'b1;
        end
        samples_in_block = n & 64'hFFFF;
        return 1'b0;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_component();
        logic signed [SAMPLE_W-1:0] v;
        v = SAMPLE_W'($urandom);
        unique case ($urandom_range(9))
            0, 1: return '0;
            2, 3, 4: return v;
            5, 6: return v >>> $urandom_range(15);
            7: begin
                unique case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return SAMPLE_W'($urandom_range(63)) - 16'sd32;
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] si,
                               input logic signed [SAMPLE_W-1:0] sq,
                               input logic known, input logic signed [DB_W-1:0] known_db);
        logic signed [DB_W-1:0] db;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_sample_i <= si;
        i_sample_q <= sq;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (absorb_sample(si, sq, db)) begin
            pending_db.push_back(known ? known_db : db);
        end
        samples_sent++;
    endtask

    task automatic set_block_length(input logic [COUNT_W-1:0] len);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        block_len = len;
        lengths_used++;
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (pending_db.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random pop, check each transfer against the oldest expectation
    always @(posedge i_clk) begin
        logic signed [DB_W-1:0] want;
        if (i_rst_n && pop && !empty) begin
            if (pending_db.size() == 0) begin
                flag_mismatch($sformatf("unexpected power result %0d", o_power_db));
            end else begin
                want = pending_db.pop_front();
                if (o_power_db !== want) begin
                    flag_mismatch($sformatf("power_db %0d, expected %0d", o_power_db, want));
                end
                results_checked++;
            end
        end
        pop <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pending_db.size());
            $display("decimating_power_meter_db_test: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        push       = 1'b0;
        pop        = 1'b0;
        i_sample_i = '0;
        i_sample_q = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        error_count = 0;
        samples_sent = 0;
        results_checked = 0;
        lengths_used = 1;
        cycle_count = 0;
        block_len = RESET_BLOCK_LEN;
        power_acc = 0;
        samples_in_block = 0;

        directed_rows = '{
            '{16'sh0000, 16'sh0000, 1'b1, DB_MIN},        // zero power
            '{16'sh8000, 16'sh8000, 1'b1, 16'sd771},
            '{16'sh8000, 16'sh0000, 1'b1, 16'sd0},
            '{16'sh0000, 16'sh8000, 1'b1, 16'sd0},
            '{16'sh0001, 16'sh0000, 1'b1, -16'sd23119},
            '{16'sh0000, 16'sh0001, 1'b1, -16'sd23119},
            '{16'shFFFF, 16'sh0000, 1'b1, -16'sd23119},
            '{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sd0},
            '{16'sh7FFF, 16'sh8000, 1'b0, 16'sd0},
            '{16'sh8000, 16'sh7FFF, 1'b0, 16'sd0},
            '{16'sh7FFF, 16'sh0000, 1'b0, 16'sd0},
            '{16'sh0000, 16'sh7FFF, 1'b0, 16'sd0},
            '{16'shFFFF, 16'shFFFF, 1'b0, 16'sd0},
            '{16'sh5555, 16'shAAAA, 1'b0, 16'sd0},
            '{16'shAAAA, 16'sh5555, 1'b0, 16'sd0},
            '{16'sh4000, 16'sh0000, 1'b0, 16'sd0},
            '{16'sh0100, 16'sh0100, 1'b0, 16'sd0}
        };

        // length, idle %, stall %, samples
        phase_plan = '{
            '{16'd1,     8'd0,  8'd0,  16'd34},
            '{16'd0,     8'd71, 8'd0,  16'd34},
            '{16'd2,     8'd0,  8'd71, 16'd34},
            '{16'd65535, 8'd35, 8'd35, 16'd34},   // left open, closed by next length
            '{16'd3,     8'd0,  8'd0,  16'd34},
            '{16'd16,    8'd71, 8'd0,  16'd34},
            '{16'd5,     8'd0,  8'd71, 16'd34},
            '{16'd1,     8'd35, 8'd35, 16'd34},
            '{16'd40,    8'd0,  8'd0,  16'd34},
            '{16'd7,     8'd35, 8'd35, 16'd34},
            '{16'd1000,  8'd0,  8'd71, 16'd34},
            '{16'd4,     8'd71, 8'd0,  16'd34}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // block length left at its reset value
        for (int k = 0; k < RESET_BLOCK_LEN; k++) begin
            send_sample(rand_component(), rand_component(), 1'b0, '0);
        end
        wait_for_results();

        set_block_length(16'd1);
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_sample(directed_rows[k].si, directed_rows[k].sq,
                        directed_rows[k].known, directed_rows[k].db);
        end
        wait_for_results();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_pct  = phase_plan[ph].idle_pct;
            stall_pct = phase_plan[ph].stall_pct;
            set_block_length(phase_plan[ph].block_len);
            for (int k = 0; k < phase_plan[ph].n_samples; k++) begin
                send_sample(rand_component(), rand_component(), 1'b0, '0);
            end
            wait_for_results();
        end

        if (pending_db.size() != 0) begin
            flag_mismatch($sformatf("%0d power results never arrived", pending_db.size()));
        end
        $display("%0d samples, %0d power results checked, %0d block length settings",
                 samples_sent, results_checked, lengths_used);
        $display("%0d mismatches", error_count);
        if (error_count == 0) begin
            $display("decimating_power_meter_db_test: PASS");
        end else begin
            $display("decimating_power_meter_db_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/dpm_pkg.sv
hw/rtl/dpm_front.sv
hw/rtl/dpm_jobq.sv
hw/rtl/dpm_log2.sv
hw/rtl/dpm_back.sv
hw/rtl/decimating_power_meter_db.sv
verif/decimating_power_meter_db_test.sv
